// ===== rtl/core/rvdec_pkg.sv =====
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and encodings for the RV32IM instruction decoder.
// ----------------------------------------------------------------------------
package rvdec_pkg;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] F7_ALT     = 7'h20;
  localparam logic [6:0] F7_MULDIV  = 7'h01;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_LEGAL   = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  localparam logic [2:0] UNIT_ALU = 3'd0;
  localparam logic [2:0] UNIT_BRU = 3'd1;
  localparam logic [2:0] UNIT_LSU = 3'd2;
  localparam logic [2:0] UNIT_MUL = 3'd3;
  localparam logic [2:0] UNIT_DIV = 3'd4;
  localparam logic [2:0] UNIT_CSR = 3'd5;

  localparam logic [1:0] SRC_NONE = 2'd0;
  localparam logic [1:0] SRC_REG  = 2'd1;
  localparam logic [1:0] SRC_IMM  = 2'd2;

  typedef struct packed {
    logic        en;
    logic [31:0] pc;
    logic [31:0] word;
  } slot_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pc;
    logic [5:0]  op;
    logic [2:0]  unit;
    logic [3:0]  sub;
    logic [3:0]  args;
    logic [4:0]  r1;
    logic [4:0]  r2;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [11:0] csr;
    logic [3:0]  flags;
  } uop_t;

endpackage

// ===== rtl/core/rvdec_logic.sv =====
// ----------------------------------------------------------------------------
// rvdec_logic
// Combinational decode of one instruction slot into a micro-op.
// ----------------------------------------------------------------------------
module rvdec_logic (
  input  rvdec_pkg::slot_t slot,
  output rvdec_pkg::uop_t  uop
);

  logic [31:0] w;
  logic [6:0]  opc, f7;
  logic [4:0]  f_rd, f_rs1, f_rs2;
  logic [2:0]  f3;
  logic [11:0] imm_i;
  logic [31:0] sx_i, sx_s, sx_b, sx_j;
  logic [5:0]  op;
  logic [2:0]  unit;
  logic [3:0]  sub;
  logic [1:0]  a1, a2;
  logic [4:0]  r1, r2, rd;
  logic [31:0] imm;
  logic [11:0] csr;
  logic        wen, bad;

  assign w     = slot.word;
  assign opc   = w[6:0];
  assign f_rd  = w[11:7];
  assign f3    = w[14:12];
  assign f_rs1 = w[19:15];
  assign f_rs2 = w[24:20];
  assign f7    = w[31:25];
  assign imm_i = w[31:20];
  assign sx_i  = {{20{w[31]}}, w[31:20]};
  assign sx_s  = {{20{w[31]}}, w[31:25], w[11:7]};
  assign sx_b  = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
  assign sx_j  = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};

  always_comb begin
    op = '0; unit = rvdec_pkg::UNIT_ALU; sub = '0;
    a1 = rvdec_pkg::SRC_NONE; a2 = rvdec_pkg::SRC_NONE;
    r1 = '0; r2 = '0; rd = '0; imm = '0; csr = '0; wen = 1'b0; bad = 1'b0;
    unique case (opc)
      rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC: begin
        op  = (opc == rvdec_pkg::OPC_LUI) ? 6'd1 : 6'd2;
        sub = (opc == rvdec_pkg::OPC_LUI) ? 4'd0 : 4'd1;
        imm = {w[31:12], 12'h000}; rd = f_rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_JAL: begin
        op = 6'd3; unit = rvdec_pkg::UNIT_BRU; imm = sx_j; rd = f_rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_JALR: begin
        op = 6'd4; unit = rvdec_pkg::UNIT_BRU; sub = 4'd1;
        a1 = rvdec_pkg::SRC_REG; r1 = f_rs1; imm = sx_i; rd = f_rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_BRANCH: begin
        unit = rvdec_pkg::UNIT_BRU; a1 = rvdec_pkg::SRC_REG; r1 = f_rs1;
        a2 = rvdec_pkg::SRC_REG; r2 = f_rs2; imm = sx_b;
        case (f3)
          3'd0, 3'd1: begin op = 6'd5 + {3'd0, f3}; sub = 4'd2 + {1'b0, f3}; end
          3'd2, 3'd3: bad = 1'b1;
          default: begin op = 6'd3 + {3'd0, f3}; sub = {1'b0, f3}; end
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        unit = rvdec_pkg::UNIT_LSU; a1 = rvdec_pkg::SRC_REG; r1 = f_rs1;
        imm = sx_i; rd = f_rd; wen = 1'b1;
        case (f3)
          3'd0, 3'd1, 3'd2: begin op = 6'd11 + {3'd0, f3}; sub = {1'b0, f3}; end
          3'd4, 3'd5: begin op = 6'd10 + {3'd0, f3}; sub = {1'b0, f3} - 4'd1; end
          default: bad = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        unit = rvdec_pkg::UNIT_LSU; a1 = rvdec_pkg::SRC_REG; r1 = f_rs1;
        a2 = rvdec_pkg::SRC_REG; r2 = f_rs2; imm = sx_s;
        if (f3 <= 3'd2) begin
          op = 6'd16 + {3'd0, f3}; sub = 4'd5 + {1'b0, f3};
        end else begin
          bad = 1'b1;
        end
      end
      rvdec_pkg::OPC_OPIMM: begin
        a1 = rvdec_pkg::SRC_REG; r1 = f_rs1; a2 = rvdec_pkg::SRC_IMM;
        imm = sx_i; rd = f_rd; wen = 1'b1;
        case (f3)
          3'd0: begin op = 6'd19; sub = 4'd2; end
          3'd1: if (f7 == 7'd0) begin op = 6'd25; sub = 4'd4; end else bad = 1'b1;
          3'd2: begin op = 6'd20; sub = 4'd5; end
          3'd3: begin op = 6'd21; sub = 4'd6; end
          3'd4: begin op = 6'd22; sub = 4'd7; end
          3'd5: begin
            if (f7 == 7'd0) begin op = 6'd26; sub = 4'd8; end
            else if (f7 == rvdec_pkg::F7_ALT) begin op = 6'd27; sub = 4'd9; end
            else bad = 1'b1;
          end
          3'd6: begin op = 6'd23; sub = 4'd10; end
          default: begin op = 6'd24; sub = 4'd11; end
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        a1 = rvdec_pkg::SRC_REG; r1 = f_rs1; a2 = rvdec_pkg::SRC_REG; r2 = f_rs2;
        rd = f_rd; wen = 1'b1;
        if (f7 == 7'd0) begin
          case (f3)
            3'd0: begin op = 6'd28; sub = 4'd2; end
            3'd1: begin op = 6'd30; sub = 4'd4; end
            3'd2: begin op = 6'd31; sub = 4'd5; end
            3'd3: begin op = 6'd32; sub = 4'd6; end
            3'd4: begin op = 6'd33; sub = 4'd7; end
            3'd5: begin op = 6'd34; sub = 4'd8; end
            3'd6: begin op = 6'd36; sub = 4'd10; end
            default: begin op = 6'd37; sub = 4'd11; end
          endcase
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
          op = 6'd29; sub = 4'd3;
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
          op = 6'd35; sub = 4'd9;
        end else if (f7 == rvdec_pkg::F7_MULDIV) begin
          op   = 6'd38 + {3'd0, f3};
          unit = f3[2] ? rvdec_pkg::UNIT_DIV : rvdec_pkg::UNIT_MUL;
          sub  = {2'b00, f3[1:0]};
        end else begin
          bad = 1'b1;
        end
      end
      rvdec_pkg::OPC_FENCE: begin
        if (f3 == 3'd0 && f_rd == 5'd0 && f_rs1 == 5'd0 && w[31:28] == 4'd0) begin
          op = 6'd46; sub = 4'd12; imm = {20'd0, imm_i};
        end else if (f3 == 3'd1 && f_rd == 5'd0 && f_rs1 == 5'd0 && imm_i == 12'd0) begin
          op = 6'd47; sub = 4'd13;
        end else begin
          bad = 1'b1;
        end
      end
      rvdec_pkg::OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (f_rd == 5'd0 && f_rs1 == 5'd0 && imm_i <= 12'd1) begin
            op = 6'd48 + {5'd0, imm_i[0]}; sub = 4'd14 + {3'd0, imm_i[0]};
          end else begin
            bad = 1'b1;
          end
        end else if (f3 == 3'd4) begin
          bad = 1'b1;
        end else begin
          unit = rvdec_pkg::UNIT_CSR; csr = imm_i; rd = f_rd; wen = 1'b1;
          sub  = {2'b00, f3[1:0]} - 4'd1;
          if (!f3[2]) begin
            op = 6'd49 + {3'd0, f3}; a1 = rvdec_pkg::SRC_REG; r1 = f_rs1;
          end else begin
            op = 6'd48 + {3'd0, f3}; a1 = rvdec_pkg::SRC_IMM; imm = {27'd0, f_rs1};
          end
        end
      end
      default: bad = 1'b1;
    endcase
  end

  always_comb begin
    uop = '0;
    if (slot.en) begin
      uop.status = bad ? rvdec_pkg::ST_ILLEGAL : rvdec_pkg::ST_LEGAL;
      uop.pc     = slot.pc;
      uop.op     = bad ? 6'd0 : op;
      uop.unit   = unit;
      uop.sub    = bad ? 4'd0 : sub;
      uop.args   = {a2, a1};
      uop.r1     = r1;
      uop.r2     = r2;
      uop.rd     = rd;
      uop.imm    = imm;
      uop.csr    = csr;
      uop.flags  = {wen && rd != 5'd0,
                    a2 == rvdec_pkg::SRC_REG && r2 != 5'd0,
                    a1 == rvdec_pkg::SRC_REG && r1 != 5'd0,
                    wen};
    end
  end

endmodule

// ===== rtl/core/rv32im_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// rv32im_instruction_decoder
// RV32IM, Zicsr and fence decoder for one fetch slot, one transfer per cycle.
// ----------------------------------------------------------------------------
// A transfer is taken at each rising edge where start is high; busy is always
// low, so an instruction can be presented every cycle. The slot is captured in
// an input register, decoded by combinational logic in the next cycle and
// caught in the result register, so each result appears with done high for
// one cycle. The receiver cannot stall the
// block and must take every result in the cycle where done is high. The
// block has two register stages, input and result, around the decode logic.
module rv32im_instruction_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               slot_enable,
  input  logic [31:0]        fetch_pc,
  input  logic [31:0]        instr_word,
  output logic               done,
  output logic [1:0]         slot_status,
  output logic [31:0]        uop_pc,
  output logic [5:0]         op_kind,
  output logic [2:0]         exec_unit,
  output logic [3:0]         unit_subop,
  output logic [3:0]         arg_sources,
  output logic [4:0]         src1_reg,
  output logic [4:0]         src2_reg,
  output logic [4:0]         dest_reg,
  output logic signed [31:0] immediate,
  output logic [11:0]        csr_addr,
  output logic [3:0]         reg_flags
);

  rvdec_pkg::slot_t slot;
  rvdec_pkg::uop_t  uop_next, uop;
  logic             slot_valid, done_q;

  // The decoder never refuses a transfer.
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      slot_valid <= start;
      done_q     <= slot_valid;
    end
    if (start) begin
      slot <= '{en: slot_enable, pc: fetch_pc, word: instr_word};
    end
    if (slot_valid) begin
      uop <= uop_next;
    end
  end

  rvdec_logic u_logic (
    .slot (slot),
    .uop  (uop_next)
  );

  assign done        = done_q;
  assign slot_status = uop.status;
  assign uop_pc      = uop.pc;
  assign op_kind     = uop.op;
  assign exec_unit   = uop.unit;
  assign unit_subop  = uop.sub;
  assign arg_sources = uop.args;
  assign src1_reg    = uop.r1;
  assign src2_reg    = uop.r2;
  assign dest_reg    = uop.rd;
  assign immediate   = uop.imm;
  assign csr_addr    = uop.csr;
  assign reg_flags   = uop.flags;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RV32IM instruction decoder. Directed encodings
// from each opcode group and some illegal forms precede random instructions,
// mostly well-formed, with or without sender gaps. A local decoder model
// predicts each micro-op and a checker compares every strobed result.
// ----------------------------------------------------------------------------
module tb_top;

  // Operation codes as the decoder reports them in op_kind.
  localparam logic [5:0] OP_NONE = 6'd0, OP_LUI = 6'd1, OP_AUIPC = 6'd2, OP_JAL = 6'd3,
    OP_JALR = 6'd4, OP_BEQ = 6'd5, OP_BNE = 6'd6, OP_BLT = 6'd7, OP_BGE = 6'd8,
    OP_BLTU = 6'd9, OP_BGEU = 6'd10, OP_LB = 6'd11, OP_LH = 6'd12, OP_LW = 6'd13,
    OP_LBU = 6'd14, OP_LHU = 6'd15, OP_SB = 6'd16, OP_SH = 6'd17, OP_SW = 6'd18;
  localparam logic [5:0] OP_ADDI = 6'd19, OP_SLTI = 6'd20, OP_SLTIU = 6'd21,
    OP_XORI = 6'd22, OP_ORI = 6'd23, OP_ANDI = 6'd24, OP_SLLI = 6'd25, OP_SRLI = 6'd26,
    OP_SRAI = 6'd27, OP_ADD = 6'd28, OP_SUB = 6'd29, OP_SLL = 6'd30, OP_SLT = 6'd31,
    OP_SLTU = 6'd32, OP_XOR = 6'd33, OP_SRL = 6'd34, OP_SRA = 6'd35, OP_OR = 6'd36,
    OP_AND = 6'd37, OP_MUL = 6'd38;
  localparam logic [5:0] OP_FENCE = 6'd46, OP_FENCE_I = 6'd47, OP_ECALL = 6'd48,
    OP_EBREAK = 6'd49, OP_CSRRW = 6'd50, OP_CSRRS = 6'd51, OP_CSRRC = 6'd52,
    OP_CSRRWI = 6'd53, OP_CSRRSI = 6'd54, OP_CSRRCI = 6'd55;

  // Sub-op codes within each unit.
  localparam logic [3:0] SUB_LUI = 4'd0, SUB_AUIPC = 4'd1, SUB_ADD = 4'd2, SUB_SUB = 4'd3,
    SUB_SLL = 4'd4, SUB_SLT = 4'd5, SUB_SLTU = 4'd6, SUB_XOR = 4'd7, SUB_SRL = 4'd8,
    SUB_SRA = 4'd9, SUB_OR = 4'd10, SUB_AND = 4'd11, SUB_FENCE = 4'd12,
    SUB_FENCE_I = 4'd13, SUB_ECALL = 4'd14, SUB_EBREAK = 4'd15;
  localparam logic [3:0] SUB_JAL = 4'd0, SUB_JALR = 4'd1, SUB_BEQ = 4'd2, SUB_BNE = 4'd3,
    SUB_BLT = 4'd4, SUB_BGE = 4'd5, SUB_BLTU = 4'd6, SUB_BGEU = 4'd7;
  localparam logic [3:0] SUB_LB = 4'd0, SUB_LH = 4'd1, SUB_LW = 4'd2, SUB_LBU = 4'd3,
    SUB_LHU = 4'd4, SUB_SB = 4'd5, SUB_SH = 4'd6, SUB_SW = 4'd7;
  localparam logic [3:0] SUB_CSRRW = 4'd0, SUB_CSRRS = 4'd1, SUB_CSRRC = 4'd2;

  localparam int LIMIT = 200000;

  logic clk, rst, start, busy, slot_enable, done;
  logic [31:0] fetch_pc, instr_word;
  rvdec_pkg::uop_t got;
  logic signed [31:0] imm_out;

  rvdec_pkg::uop_t uop_queue[$];
  int errors = 0;
  int cycles = 0;

  rv32im_instruction_decoder DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .slot_enable(slot_enable), .fetch_pc(fetch_pc), .instr_word(instr_word),
    .done(done), .slot_status(got.status), .uop_pc(got.pc), .op_kind(got.op),
    .exec_unit(got.unit), .unit_subop(got.sub), .arg_sources(got.args),
    .src1_reg(got.r1), .src2_reg(got.r2), .dest_reg(got.rd), .immediate(imm_out),
    .csr_addr(got.csr), .reg_flags(got.flags)
  );
  assign got.imm = imm_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Decode model: fields that an opcode group fills before its funct check
  // survive a failed check, while op and sub are cleared.
  function automatic rvdec_pkg::uop_t decode_uop(logic en, logic [31:0] pc,
                                                 logic [31:0] w);
    rvdec_pkg::uop_t u;
    logic [6:0] opc, f7;
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [11:0] ii;
    logic [31:0] sx_i;
    logic wen, bad;
    u = '0;
    opc = w[6:0]; rd = w[11:7]; rs1 = w[19:15]; rs2 = w[24:20]; f3 = w[14:12];
    f7 = w[31:25]; ii = w[31:20];
    sx_i = {{20{ii[11]}}, ii};
    wen = 1'b0; bad = 1'b0;
    if (!en) return u;
    u.status = rvdec_pkg::ST_LEGAL;
    u.pc = pc;
    case (opc)
      rvdec_pkg::OPC_LUI: begin
        u.op = OP_LUI; u.sub = SUB_LUI;
        u.imm = {w[31:12], 12'h0}; u.rd = rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_AUIPC: begin
        u.op = OP_AUIPC; u.sub = SUB_AUIPC;
        u.imm = {w[31:12], 12'h0}; u.rd = rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_JAL: begin
        u.op = OP_JAL; u.unit = rvdec_pkg::UNIT_BRU; u.sub = SUB_JAL;
        u.imm = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0}; u.rd = rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_JALR: begin
        u.op = OP_JALR; u.unit = rvdec_pkg::UNIT_BRU; u.sub = SUB_JALR;
        u.args[1:0] = rvdec_pkg::SRC_REG; u.r1 = rs1;
        u.imm = sx_i; u.rd = rd; wen = 1'b1;
      end
      rvdec_pkg::OPC_BRANCH: begin
        u.unit = rvdec_pkg::UNIT_BRU;
        u.args = {rvdec_pkg::SRC_REG, rvdec_pkg::SRC_REG}; u.r1 = rs1; u.r2 = rs2;
        u.imm = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: begin u.op = OP_BEQ; u.sub = SUB_BEQ; end
          3'd1: begin u.op = OP_BNE; u.sub = SUB_BNE; end
          3'd4: begin u.op = OP_BLT; u.sub = SUB_BLT; end
          3'd5: begin u.op = OP_BGE; u.sub = SUB_BGE; end
          3'd6: begin u.op = OP_BLTU; u.sub = SUB_BLTU; end
          3'd7: begin u.op = OP_BGEU; u.sub = SUB_BGEU; end
          default: bad = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_LOAD: begin
        u.unit = rvdec_pkg::UNIT_LSU; u.args[1:0] = rvdec_pkg::SRC_REG; u.r1 = rs1;
        u.imm = sx_i; u.rd = rd; wen = 1'b1;
        case (f3)
          3'd0: begin u.op = OP_LB; u.sub = SUB_LB; end
          3'd1: begin u.op = OP_LH; u.sub = SUB_LH; end
          3'd2: begin u.op = OP_LW; u.sub = SUB_LW; end
          3'd4: begin u.op = OP_LBU; u.sub = SUB_LBU; end
          3'd5: begin u.op = OP_LHU; u.sub = SUB_LHU; end
          default: bad = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_STORE: begin
        u.unit = rvdec_pkg::UNIT_LSU;
        u.args = {rvdec_pkg::SRC_REG, rvdec_pkg::SRC_REG}; u.r1 = rs1; u.r2 = rs2;
        u.imm = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          3'd0: begin u.op = OP_SB; u.sub = SUB_SB; end
          3'd1: begin u.op = OP_SH; u.sub = SUB_SH; end
          3'd2: begin u.op = OP_SW; u.sub = SUB_SW; end
          default: bad = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_OPIMM: begin
        u.args = {rvdec_pkg::SRC_IMM, rvdec_pkg::SRC_REG}; u.r1 = rs1;
        u.imm = sx_i; u.rd = rd; wen = 1'b1;
        case (f3)
          3'd0: begin u.op = OP_ADDI; u.sub = SUB_ADD; end
          3'd2: begin u.op = OP_SLTI; u.sub = SUB_SLT; end
          3'd3: begin u.op = OP_SLTIU; u.sub = SUB_SLTU; end
          3'd4: begin u.op = OP_XORI; u.sub = SUB_XOR; end
          3'd6: begin u.op = OP_ORI; u.sub = SUB_OR; end
          3'd7: begin u.op = OP_ANDI; u.sub = SUB_AND; end
          3'd1: if (f7 == 7'h0) begin u.op = OP_SLLI; u.sub = SUB_SLL; end
                else bad = 1'b1;
          default: if (f7 == 7'h0) begin u.op = OP_SRLI; u.sub = SUB_SRL; end
                   else if (f7 == rvdec_pkg::F7_ALT) begin
                     u.op = OP_SRAI; u.sub = SUB_SRA;
                   end else bad = 1'b1;
        endcase
      end
      rvdec_pkg::OPC_OP: begin
        u.args = {rvdec_pkg::SRC_REG, rvdec_pkg::SRC_REG}; u.r1 = rs1; u.r2 = rs2;
        u.rd = rd; wen = 1'b1;
        if (f7 == 7'h0) begin
          case (f3)
            3'd0: begin u.op = OP_ADD; u.sub = SUB_ADD; end
            3'd1: begin u.op = OP_SLL; u.sub = SUB_SLL; end
            3'd2: begin u.op = OP_SLT; u.sub = SUB_SLT; end
            3'd3: begin u.op = OP_SLTU; u.sub = SUB_SLTU; end
            3'd4: begin u.op = OP_XOR; u.sub = SUB_XOR; end
            3'd5: begin u.op = OP_SRL; u.sub = SUB_SRL; end
            3'd6: begin u.op = OP_OR; u.sub = SUB_OR; end
            default: begin u.op = OP_AND; u.sub = SUB_AND; end
          endcase
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
          u.op = OP_SUB; u.sub = SUB_SUB;
        end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
          u.op = OP_SRA; u.sub = SUB_SRA;
        end else if (f7 == rvdec_pkg::F7_MULDIV) begin
          u.op = OP_MUL + {3'd0, f3};
          u.unit = f3[2] ? rvdec_pkg::UNIT_DIV : rvdec_pkg::UNIT_MUL;
          u.sub = {2'b0, f3[1:0]};
        end else bad = 1'b1;
      end
      rvdec_pkg::OPC_FENCE: begin
        if (f3 == 3'd0 && rd == 5'd0 && rs1 == 5'd0 && w[31:28] == 4'h0) begin
          u.op = OP_FENCE; u.sub = SUB_FENCE; u.imm = {20'h0, ii};
        end else if (f3 == 3'd1 && rd == 5'd0 && rs1 == 5'd0 && ii == 12'd0) begin
          u.op = OP_FENCE_I; u.sub = SUB_FENCE_I;
        end else bad = 1'b1;
      end
      rvdec_pkg::OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (rd == 5'd0 && rs1 == 5'd0 && ii == 12'd0) begin
            u.op = OP_ECALL; u.sub = SUB_ECALL;
          end else if (rd == 5'd0 && rs1 == 5'd0 && ii == 12'd1) begin
            u.op = OP_EBREAK; u.sub = SUB_EBREAK;
          end else bad = 1'b1;
        end else if (f3 == 3'd4) bad = 1'b1;
        else begin
          u.unit = rvdec_pkg::UNIT_CSR; u.csr = ii; u.rd = rd; wen = 1'b1;
          if (!f3[2]) begin
            u.args[1:0] = rvdec_pkg::SRC_REG; u.r1 = rs1;
          end else begin
            u.args[1:0] = rvdec_pkg::SRC_IMM; u.imm = {27'h0, rs1};
          end
          case (f3[1:0])
            2'd1: begin u.op = f3[2] ? OP_CSRRWI : OP_CSRRW; u.sub = SUB_CSRRW; end
            2'd2: begin u.op = f3[2] ? OP_CSRRSI : OP_CSRRS; u.sub = SUB_CSRRS; end
            default: begin u.op = f3[2] ? OP_CSRRCI : OP_CSRRC; u.sub = SUB_CSRRC; end
          endcase
        end
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      u.status = rvdec_pkg::ST_ILLEGAL; u.op = OP_NONE; u.sub = 4'd0;
    end
    u.flags = {wen && u.rd != 5'd0,
               u.args[3:2] == rvdec_pkg::SRC_REG && u.r2 != 5'd0,
               u.args[1:0] == rvdec_pkg::SRC_REG && u.r1 != 5'd0,
               wen};
    return u;
  endfunction

  // Presents one slot and holds it until the decoder takes the transfer.
  // Gaps are inserted ahead of the item when idling is enabled.
  bit idle_on = 1'b1;

  task automatic send_slot(logic en, logic [31:0] pc, logic [31:0] w);
    while (idle_on && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    slot_enable <= en;
    fetch_pc <= pc;
    instr_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    uop_queue.push_back(decode_uop(en, pc, w));
  endtask

  task automatic release_bus();
    start <= 1'b0;
    @(posedge clk);
  endtask

  // Every strobed result must match the oldest predicted micro-op.
  always @(posedge clk) begin
    rvdec_pkg::uop_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (uop_queue.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        e = uop_queue.pop_front();
        if (got.status !== e.status) begin
          $error("slot_status exp %0d got %0d", e.status, got.status); errors++; end
        if (got.pc !== e.pc) begin
          $error("uop_pc exp %h got %h", e.pc, got.pc); errors++; end
        if (got.op !== e.op) begin
          $error("op_kind exp %0d got %0d", e.op, got.op); errors++; end
        if (got.unit !== e.unit) begin
          $error("exec_unit exp %0d got %0d", e.unit, got.unit); errors++; end
        if (got.sub !== e.sub) begin
          $error("unit_subop exp %0d got %0d", e.sub, got.sub); errors++; end
        if (got.args !== e.args) begin
          $error("arg_sources exp %0d got %0d", e.args, got.args); errors++; end
        if (got.r1 !== e.r1) begin
          $error("src1_reg exp %0d got %0d", e.r1, got.r1); errors++; end
        if (got.r2 !== e.r2) begin
          $error("src2_reg exp %0d got %0d", e.r2, got.r2); errors++; end
        if (got.rd !== e.rd) begin
          $error("dest_reg exp %0d got %0d", e.rd, got.rd); errors++; end
        if (got.imm !== e.imm) begin
          $error("immediate exp %h got %h", e.imm, got.imm); errors++; end
        if (got.csr !== e.csr) begin
          $error("csr_addr exp %h got %h", e.csr, got.csr); errors++; end
        if (got.flags !== e.flags) begin
          $error("reg_flags exp %b got %b", e.flags, got.flags); errors++; end
      end
    end
  end

  // Hard stop in case the decoder stalls or stops strobing results.
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Builds an encoding for a random opcode group, with random
  // register fields and immediates; funct fields mostly legal.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [6:0] opcs[11];
    opcs = '{rvdec_pkg::OPC_LUI, rvdec_pkg::OPC_AUIPC, rvdec_pkg::OPC_JAL,
             rvdec_pkg::OPC_JALR, rvdec_pkg::OPC_BRANCH, rvdec_pkg::OPC_LOAD,
             rvdec_pkg::OPC_STORE, rvdec_pkg::OPC_OPIMM, rvdec_pkg::OPC_OP,
             rvdec_pkg::OPC_FENCE, rvdec_pkg::OPC_SYSTEM};
    w = $urandom;
    w[6:0] = opcs[$urandom_range(10)];
    if (w[6:0] == rvdec_pkg::OPC_OP || w[6:0] == rvdec_pkg::OPC_OPIMM) begin
      case ($urandom_range(3))
        0: w[31:25] = 7'h0;
        1: w[31:25] = rvdec_pkg::F7_ALT;
        2: w[31:25] = rvdec_pkg::F7_MULDIV;
        default: ;
      endcase
    end
    if (w[6:0] == rvdec_pkg::OPC_FENCE && $urandom_range(3) != 0) begin
      w[19:15] = 5'd0; w[11:7] = 5'd0;
      w[14:12] = 3'($urandom_range(1));
      if (w[12]) w[31:20] = 12'h0; else w[31:28] = 4'h0;
    end
    if (w[6:0] == rvdec_pkg::OPC_SYSTEM && w[14:12] == 3'd0 && $urandom_range(1) != 0)
    begin
      w[31:7] = {11'h0, w[20], 13'h0};
    end
    return w;
  endfunction

  task automatic test_directed();
    logic [31:0] words[$];
    words = '{32'h0000_0037, 32'hffff_ffb7, 32'h8000_0017, 32'hffff_f0ef, 32'h8000_00ef,
              32'hfff0_8067, 32'h7ff0_8f67, 32'hfe20_8ee3, 32'h0020_a063,
              32'hfff0_7f83, 32'h0000_3003, 32'h8020_2023, 32'h0000_3023,
              32'hfff0_0f93, 32'h4010_5093, 32'h0200_1093, 32'h4000_0fb3,
              32'h0210_4033, 32'h8000_0033, 32'h0ff0_000f, 32'h1000_000f,
              32'h0000_100f, 32'h0010_0073, 32'hfff7_9ff3, 32'h0000_4073,
              32'hffff_ffff};
    send_slot(1'b0, 32'hdead_beef, 32'h0000_0033);
    foreach (words[i]) send_slot(1'b1, 32'hffff_fffc - 32'(i), words[i]);
    send_slot(1'b1, 32'h0, 32'h0);
    release_bus();
  endtask

  task automatic test_random(int count, bit gaps);
    logic [31:0] w;
    idle_on = gaps;
    repeat (count) begin
      w = ($urandom_range(9) == 0) ? $urandom : random_instr();
      send_slot($urandom_range(15) != 0, $urandom, w);
    end
    release_bus();
    idle_on = 1'b1;
  endtask

  // Holds the sender back until every predicted micro-op has been checked.
  task automatic drain();
    while (uop_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    slot_enable = 1'b0;
    fetch_pc = '0;
    instr_word = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_random(300, 1'b1);
    test_random(200, 1'b0);
    drain();
    test_random(300, 1'b1);
    drain();
    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
